[rtl/core/assert_macros.svh]
// Assertion macros shared by the sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/rgbs_pkg.sv]
// Package: command, status and state codes for the grid sampler.
package rgbs_pkg;
   localparam logic [2:0] CMD_WR_STATION = 3'd0;
   localparam logic [2:0] CMD_WR_DEPTH   = 3'd1;
   localparam logic [2:0] CMD_WR_CELL    = 3'd2;
   localparam logic [2:0] CMD_INTERP     = 3'd3;
   localparam logic [2:0] CMD_INDEX      = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   localparam logic [1:0] CSR_STATION_LEN = 2'd0;
   localparam logic [1:0] CSR_DEPTH_LEN   = 2'd1;
   localparam logic [1:0] CSR_GRID_COLS   = 2'd2;
   localparam logic [1:0] CSR_GRID_ROWS   = 2'd3;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_SRCH   = 15'b000000000000010,
      S_SWAIT  = 15'b000000000000100,
      S_SCHK   = 15'b000000000001000,
      S_DIV    = 15'b000000000010000,
      S_CELLA  = 15'b000000000100000,
      S_CELLB  = 15'b000000001000000,
      S_CELLC  = 15'b000000010000000,
      S_CELLD  = 15'b000000100000000,
      S_MUL    = 15'b000001000000000,
      S_MULB   = 15'b000010000000000,
      S_ADD    = 15'b000100000000000,
      S_RDWAIT = 15'b001000000000000,
      S_RDOUT  = 15'b010000000000000,
      S_OUT    = 15'b100000000000000
   } state_type;
endpackage

[rtl/core/rgbs_ram.sv]
// Generic single-port RAM with registered read.
module rgbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

[rtl/core/rectilinear_grid_bilinear_sampler_unit.sv]
// Top level: rectilinear grid bilinear sampler with axis and grid memories.
// Writes are committed in S_SRCH and answered through S_OUT; index reads pass S_RDWAIT and S_RDOUT.
// Interpolation searches each axis for the interval holding the coordinate (one RAM read port),
// then a radix-2 divider yields FRAC_BITS+1 quotient bits per axis, then four cell reads and three
// lerps.
// Synchronous active-high reset clears lengths and control.
`include "assert_macros.svh"
module rectilinear_grid_bilinear_sampler_unit
   import rgbs_pkg::*;
#(
   parameter int MAX_STATIONS = 64,
   parameter int MAX_DEPTHS   = 64,
   parameter int FRAC_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[2:0], station_index[10:3], depth_index[18:11], write_value[50:19],
   // coord_x[82:51], coord_y[114:83], zero fill
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sample[31:0], status[33:32], zero fill
   output logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [6:0]   csr_wdata
);
   localparam int SW = $clog2(MAX_STATIONS);
   localparam int DW = $clog2(MAX_DEPTHS);
   localparam int GW = SW + DW;
   localparam int TW = FRAC_BITS + 9;   // position: 9 integer bits plus fraction

   logic [6:0] sl_ff, dl_ff, cols_ff, rows_ff;
   logic [8:0] sl, dl, cols, rows;
   assign sl   = ({2'b0, sl_ff}   > 9'(MAX_STATIONS)) ? 9'(MAX_STATIONS) : {2'b0, sl_ff};
   assign dl   = ({2'b0, dl_ff}   > 9'(MAX_DEPTHS))   ? 9'(MAX_DEPTHS)   : {2'b0, dl_ff};
   assign cols = ({2'b0, cols_ff} > 9'(MAX_STATIONS)) ? 9'(MAX_STATIONS) : {2'b0, cols_ff};
   assign rows = ({2'b0, rows_ff} > 9'(MAX_DEPTHS))   ? 9'(MAX_DEPTHS)   : {2'b0, rows_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_ff <= '0; dl_ff <= '0; cols_ff <= '0; rows_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STATION_LEN: sl_ff   <= csr_wdata;
            CSR_DEPTH_LEN:   dl_ff   <= csr_wdata;
            CSR_GRID_COLS:   cols_ff <= csr_wdata;
            CSR_GRID_ROWS:   rows_ff <= csr_wdata;
            default:         sl_ff   <= sl_ff;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [2:0]  cmd_ff;
   logic signed [7:0] sidx_ff, didx_ff;
   logic signed [31:0] wval_ff, cx_ff, cy_ff;
   logic        axis_ff, axis_in;             // 0 station, 1 depth
   logic [8:0]  i_ff, i_in;
   logic signed [31:0] a0_ff, a0_in;
   logic [TW-1:0] px_ff, px_in, py_ff, py_in;
   logic [32:0] num_ff, num_in;               // remainder
   logic [32:0] den_ff, den_in;
   logic [FRAC_BITS:0] q_ff, q_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic signed [31:0] c00_ff, c01_ff, c10_ff, c11_ff, r0_ff;
   logic [1:0]  lsel_ff, lsel_in;             // which lerp
   logic signed [63:0] prod_ff;
   logic signed [47:0] ipart_ff;
   logic signed [31:0] out_ff, out_in;
   logic [1:0]  stat_ff, stat_in;
   logic        rvalid_ff, rvalid_in;
   logic [SW-1:0] si_ff, si_in;
   logic [DW-1:0] di_ff, di_in;
   logic signed [31:0] c00_in, c01_in, c10_in, c11_in, r0_in;
   logic signed [63:0] prod_in;
   logic signed [47:0] ipart_in;

   logic sram_we, dram_we, gram_we;
   logic [SW-1:0] saddr;
   logic [DW-1:0] daddr;
   logic [GW-1:0] gaddr;
   logic [31:0] srd, drd, grd;

   rgbs_ram #(.WIDTH(32), .DEPTH(MAX_STATIONS)) u_sram (
      .clock, .we(sram_we), .addr(saddr), .wdata(wval_ff), .rdata(srd));
   rgbs_ram #(.WIDTH(32), .DEPTH(MAX_DEPTHS)) u_dram (
      .clock, .we(dram_we), .addr(daddr), .wdata(wval_ff), .rdata(drd));
   rgbs_ram #(.WIDTH(32), .DEPTH(MAX_STATIONS*MAX_DEPTHS)) u_gram (
      .clock, .we(gram_we), .addr(gaddr), .wdata(wval_ff), .rdata(grd));

   logic s_ok, d_ok, i_ok;
   assign s_ok = (sidx_ff >= 0) && ({1'b0, sidx_ff} < 9'(MAX_STATIONS));
   assign d_ok = (didx_ff >= 0) && ({1'b0, didx_ff} < 9'(MAX_DEPTHS));
   assign i_ok = (sidx_ff >= 0) && ({1'b0, sidx_ff} < cols)
              && (didx_ff >= 0) && ({1'b0, didx_ff} < rows);

   logic [8:0] len_cur;
   logic signed [31:0] ard, c_cur;
   assign len_cur = axis_ff ? dl : sl;
   assign ard     = axis_ff ? drd : srd;
   assign c_cur   = axis_ff ? cy_ff : cx_ff;

   // lerp operands
   logic signed [31:0] la, lb;
   logic [TW-1:0] lt;
   logic signed [32:0] ld;
   always_comb begin
      case (lsel_ff)
         2'd0:    begin la = c00_ff; lb = c01_ff; lt = px_ff - (TW'(si_ff) << FRAC_BITS); end
         2'd1:    begin la = c10_ff; lb = c11_ff; lt = px_ff - (TW'(si_ff) << FRAC_BITS); end
         default: begin la = r0_ff;  lb = out_ff; lt = py_ff - (TW'(di_ff) << FRAC_BITS); end
      endcase
   end
   assign ld = 33'(lb) - 33'(la);

   logic [8:0] si_raw, di_raw;
   assign si_raw = 9'(px_ff >> FRAC_BITS);
   assign di_raw = 9'(py_ff >> FRAC_BITS);

   logic [33:0] trial;
   assign trial = {num_ff, 1'b0} - {1'b0, den_ff};

   logic signed [66:0] sum_full;
   logic signed [31:0] sat;
   always_comb begin
      // ipart = d*ti ; prod = d*tf ; floor shift via arithmetic shift
      sum_full = 67'(la) + 67'(ipart_ff) + 67'(prod_ff >>> FRAC_BITS);
      if (sum_full > 67'sd2147483647)       sat = 32'sh7fffffff;
      else if (sum_full < -67'sd2147483648) sat = 32'sh80000000;
      else                                  sat = sum_full[31:0];
   end

   always_comb begin
      state_in = state_ff; axis_in = axis_ff; i_in = i_ff; a0_in = a0_ff;
      px_in = px_ff; py_in = py_ff; num_in = num_ff; den_in = den_ff; q_in = q_ff;
      dcnt_in = dcnt_ff; lsel_in = lsel_ff; out_in = out_ff; stat_in = stat_ff;
      rvalid_in = rvalid_ff; si_in = si_ff; di_in = di_ff;
      c00_in = c00_ff; c01_in = c01_ff; c10_in = c10_ff; c11_in = c11_ff; r0_in = r0_ff;
      prod_in = prod_ff; ipart_in = ipart_ff;
      sram_we = 1'b0; dram_we = 1'b0; gram_we = 1'b0;
      saddr = SW'(i_ff); daddr = DW'(i_ff);
      gaddr = {didx_ff[DW-1:0], sidx_ff[SW-1:0]};
      if (rvalid_ff && rsp_tready) rvalid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_SRCH;
         S_SRCH: begin
            out_in = '0; stat_in = ST_OK;
            case (cmd_ff)
               CMD_WR_STATION: begin
                  saddr = sidx_ff[SW-1:0]; sram_we = s_ok;
                  stat_in = s_ok ? ST_OK : ST_IGNORED; state_in = S_OUT;
               end
               CMD_WR_DEPTH: begin
                  daddr = didx_ff[DW-1:0]; dram_we = d_ok;
                  stat_in = d_ok ? ST_OK : ST_IGNORED; state_in = S_OUT;
               end
               CMD_WR_CELL: begin
                  gram_we = s_ok && d_ok;
                  stat_in = (s_ok && d_ok) ? ST_OK : ST_IGNORED; state_in = S_OUT;
               end
               CMD_INTERP: begin
                  if (cols < 9'd2 || rows < 9'd2 || sl < 9'd2 || dl < 9'd2) begin
                     stat_in = ST_RANGE; state_in = S_OUT;
                  end else begin
                     saddr = '0; daddr = '0;
                     axis_in = 1'b0; i_in = '0; px_in = '0; py_in = '0;
                     state_in = S_SWAIT;
                  end
               end
               CMD_INDEX: begin
                  if (i_ok) state_in = S_RDWAIT;
                  else begin stat_in = ST_RANGE; state_in = S_OUT; end
               end
               default: begin stat_in = ST_IGNORED; state_in = S_OUT; end
            endcase
         end
         S_SWAIT: begin
            // latch entry i, read i+1
            saddr = SW'(i_ff + 9'd1); daddr = DW'(i_ff + 9'd1);
            a0_in = ard; i_in = i_ff + 9'd1; state_in = S_SCHK;
         end
         S_SCHK: begin
            if (c_cur >= a0_ff && c_cur <= ard) begin
               num_in = 33'(c_cur) - 33'(a0_ff);
               den_in = 33'(ard) - 33'(a0_ff);
               q_in = '0; dcnt_in = '0; state_in = S_DIV;
            end else if (i_ff + 9'd1 < len_cur) begin
               state_in = S_SWAIT;
            end else if (!axis_ff) begin
               daddr = '0;
               axis_in = 1'b1; i_in = '0; state_in = S_SWAIT;
            end else begin
               state_in = S_CELLA;
            end
         end
         S_DIV: begin
            // restoring division of (c-a0)<<FRAC_BITS by d, one quotient bit per cycle
            if (den_ff == '0) begin
               q_in = '0; dcnt_in = 6'(FRAC_BITS + 1);
            end else if (dcnt_ff == '0) begin
               if (num_ff >= den_ff) begin
                  num_in = num_ff - den_ff; q_in = {{FRAC_BITS{1'b0}}, 1'b1};
               end
               dcnt_in = dcnt_ff + 6'd1;
            end else if (dcnt_ff <= 6'(FRAC_BITS)) begin
               if (!trial[33]) begin num_in = trial[32:0]; q_in = {q_ff[FRAC_BITS-1:0], 1'b1}; end
               else begin num_in = {num_ff[31:0], 1'b0}; q_in = {q_ff[FRAC_BITS-1:0], 1'b0}; end
               dcnt_in = dcnt_ff + 6'd1;
            end
            if (dcnt_in == 6'(FRAC_BITS + 1) || den_ff == '0) begin
               if (!axis_ff) begin
                  px_in = (TW'(i_ff - 9'd1) << FRAC_BITS) + TW'(q_in);
                  daddr = '0;
                  axis_in = 1'b1; i_in = '0; state_in = S_SWAIT;
               end else begin
                  py_in = (TW'(i_ff - 9'd1) << FRAC_BITS) + TW'(q_in);
                  state_in = S_CELLA;
               end
            end
         end
         S_CELLA: begin
            si_in = (si_raw > cols - 9'd2) ? SW'(cols - 9'd2) : SW'(si_raw);
            di_in = (di_raw > rows - 9'd2) ? DW'(rows - 9'd2) : DW'(di_raw);
            gaddr = {di_in, si_in}; state_in = S_CELLB;
         end
         S_CELLB: begin
            gaddr = {di_ff, si_ff + SW'(1)}; c00_in = grd; state_in = S_CELLC;
         end
         S_CELLC: begin
            gaddr = {di_ff + DW'(1), si_ff}; c01_in = grd; state_in = S_CELLD;
         end
         S_CELLD: begin
            gaddr = {di_ff + DW'(1), si_ff + SW'(1)}; c10_in = grd;
            lsel_in = 2'd0; state_in = S_MUL;
         end
         S_MUL: begin
            if (lsel_ff == 2'd0) c11_in = grd;
            prod_in  = 64'(ld) * 64'({1'b0, lt[FRAC_BITS-1:0]});
            state_in = S_MULB;
         end
         S_MULB: begin
            ipart_in = 48'(ld) * 48'({1'b0, lt[TW-1:FRAC_BITS]});
            state_in = S_ADD;
         end
         S_ADD: begin
            case (lsel_ff)
               2'd0:    begin r0_in = sat; lsel_in = 2'd1; state_in = S_MUL; end
               2'd1:    begin out_in = sat; lsel_in = 2'd2; state_in = S_MUL; end
               default: begin out_in = sat; state_in = S_OUT; end
            endcase
         end
         S_RDWAIT: state_in = S_RDOUT;
         S_RDOUT: begin out_in = grd; state_in = S_OUT; end
         S_OUT: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      if (req_tvalid && req_tready) begin
         cmd_ff  <= req_tdata[2:0];
         sidx_ff <= req_tdata[10:3];
         didx_ff <= req_tdata[18:11];
         wval_ff <= req_tdata[50:19];
         cx_ff   <= req_tdata[82:51];
         cy_ff   <= req_tdata[114:83];
      end
      axis_ff <= axis_in; i_ff <= i_in; a0_ff <= a0_in; px_ff <= px_in; py_ff <= py_in;
      num_ff <= num_in; den_ff <= den_in; q_ff <= q_in; dcnt_ff <= dcnt_in;
      lsel_ff <= lsel_in; si_ff <= si_in; di_ff <= di_in;
      c00_ff <= c00_in; c01_ff <= c01_in; c10_ff <= c10_in; c11_ff <= c11_in;
      r0_ff <= r0_in; prod_ff <= prod_in; ipart_ff <= ipart_in;
      if (state_ff == S_OUT && (!rvalid_ff || rsp_tready)) begin
         out_ff <= out_in; stat_ff <= stat_in;
      end else if (state_ff != S_OUT) begin
         out_ff <= out_in; stat_ff <= stat_in;
      end
   end

   logic [31:0] rsp_sample_ff;
   logic [1:0]  rsp_status_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rvalid_ff || rsp_tready)) begin
         rsp_sample_ff <= out_ff;
         rsp_status_ff <= stat_ff;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_sample_ff};

   `ASSERT_IMPL(a_ready_idle, clock, reset, req_tready, state_ff == S_IDLE, "ready outside idle")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid,
                rsp_tdata[33:32] != 2'd3, "invalid status code")
endmodule
